### src/lag_pkg.sv
`timescale 1ns / 1ps
package lag_pkg;

  localparam int ACT_W   = 2;
  localparam int COORD_W = 6;
  localparam int SURVIVE_LO = 2;
  localparam int BIRTH      = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_TOGGLE  = 2'd0,
    ACT_ADVANCE = 2'd1,
    ACT_QUERY   = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL_RD,
    ST_CELL_FIN,
    ST_ADV_RD,
    ST_ADV_LOAD,
    ST_ADV_ROW
  } state_e;

  typedef struct packed {
    logic clr_wr;
    logic take;
    logic cell_rd;
    logic cell_fin;
    logic adv_rd;
    logic adv_load;
    logic adv_row;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic row_last;
    logic in_adv;
    logic out_busy;
  } sts_t;

endpackage

### src/lag_in_if.sv
`timescale 1ns / 1ps
interface lag_in_if;
  logic                        valid;
  logic                        ready;
  logic [lag_pkg::ACT_W-1:0]   action;
  logic [lag_pkg::COORD_W-1:0] row;
  logic [lag_pkg::COORD_W-1:0] column;

  modport source (output valid, action, row, column, input ready);
  modport sink (input valid, action, row, column, output ready);
endinterface

### src/lag_out_if.sv
`timescale 1ns / 1ps
interface lag_out_if;
  logic valid;
  logic ready;
  logic alive;
  logic done_res;

  modport source (output valid, alive, done_res, input ready);
  modport sink (input valid, alive, done_res, output ready);
endinterface

### src/life_automaton_grid.sv
`timescale 1ns / 1ps
// toggle and query: read the row, then finish and register the result; one item at a time
// advance: read and load the first rows, then one grid row per cycle through the row memory port
// next item is accepted once the previous result has been taken
// reset is asynchronous; afterwards a clearing pass writes zero to every grid row
// no item is accepted during the clearing pass
module life_automaton_grid #(
  parameter int ROWS = 64,
  parameter int COLS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lag_in_if.sink    in_i,
  lag_out_if.source out_o
);

  lag_pkg::cmd_t cmd;
  lag_pkg::sts_t sts;

  lag_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lag_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .action_i    (in_i.action),
    .row_i       (in_i.row),
    .column_i    (in_i.column),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .alive_o     (out_o.alive),
    .done_res_o  (out_o.done_res)
  );

`ifndef SYNTHESIS
  a_accept_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> !out_o.valid)
    else $error("item accepted while a result is pending");

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("more than one datapath command");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.cell_fin || (cmd.adv_row && sts.row_last)))
    else $error("result without a finishing step");
`endif

endmodule

### src/lag_ctrl.sv
`timescale 1ns / 1ps
module lag_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lag_pkg::sts_t sts_i,
  output lag_pkg::cmd_t cmd_o
);

  lag_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lag_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      lag_pkg::ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) state_d = lag_pkg::ST_IDLE;
      end
      lag_pkg::ST_IDLE: begin
        in_ready_o = !sts_i.out_busy;
        if (in_valid_i && !sts_i.out_busy) begin
          cmd_o.take = 1'b1;
          state_d = sts_i.in_adv ? lag_pkg::ST_ADV_RD : lag_pkg::ST_CELL_RD;
        end
      end
      lag_pkg::ST_CELL_RD: begin
        cmd_o.cell_rd = 1'b1;
        state_d = lag_pkg::ST_CELL_FIN;
      end
      lag_pkg::ST_CELL_FIN: begin
        cmd_o.cell_fin = 1'b1;
        state_d = lag_pkg::ST_IDLE;
      end
      lag_pkg::ST_ADV_RD: begin
        cmd_o.adv_rd = 1'b1;
        state_d = lag_pkg::ST_ADV_LOAD;
      end
      lag_pkg::ST_ADV_LOAD: begin
        cmd_o.adv_load = 1'b1;
        state_d = lag_pkg::ST_ADV_ROW;
      end
      lag_pkg::ST_ADV_ROW: begin
        cmd_o.adv_row = 1'b1;
        if (sts_i.row_last) state_d = lag_pkg::ST_IDLE;
      end
      default: state_d = lag_pkg::ST_IDLE;
    endcase
  end

endmodule

### src/lag_datapath.sv
`timescale 1ns / 1ps
module lag_datapath #(
  parameter int ROWS = 64,
  parameter int COLS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lag_pkg::cmd_t               cmd_i,
  output lag_pkg::sts_t               sts_o,
  input  logic [lag_pkg::ACT_W-1:0]   action_i,
  input  logic [lag_pkg::COORD_W-1:0] row_i,
  input  logic [lag_pkg::COORD_W-1:0] column_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        alive_o,
  output logic                        done_res_o
);

  localparam int AW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);

  logic [COLS-1:0] mem [ROWS];
  logic [COLS-1:0] rd_q, prev_q, cur_q, below, new_row, wr_data;
  logic [AW-1:0]   rd_addr, wr_addr, clr_q, r_q;
  logic            rd_en, wr_en;
  logic [lag_pkg::ACT_W-1:0]   act_q;
  logic [lag_pkg::COORD_W-1:0] row_q, col_q;
  logic            in_grid, cell_bit, out_valid_q, alive_q, done_q;
  logic [CW-1:0]   col_idx;

  assign in_grid = (32'(row_q) < ROWS) && (32'(col_q) < COLS);
  assign col_idx = CW'(col_q);
  assign cell_bit = rd_q[col_idx];

  assign sts_o.clr_last = (clr_q == AW'(ROWS - 1));
  assign sts_o.row_last = (r_q == AW'(ROWS - 1));
  assign sts_o.in_adv   = (action_i == lag_pkg::ACT_ADVANCE);
  assign sts_o.out_busy = out_valid_q;

  assign below = sts_o.row_last ? '0 : rd_q;

  always_comb begin
    logic [3:0] n;
    new_row = '0;
    for (int c = 0; c < COLS; c++) begin
      n = 4'(prev_q[c]) + 4'(below[c]);
      if (c > 0) n = n + 4'(prev_q[c-1]) + 4'(cur_q[c-1]) + 4'(below[c-1]);
      if (c < COLS - 1) n = n + 4'(prev_q[c+1]) + 4'(cur_q[c+1]) + 4'(below[c+1]);
      if (cur_q[c]) new_row[c] = (n == 4'(lag_pkg::SURVIVE_LO)) || (n == 4'(lag_pkg::BIRTH));
      else          new_row[c] = (n == 4'(lag_pkg::BIRTH));
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    if (cmd_i.cell_rd) begin
      rd_en   = 1'b1;
      rd_addr = AW'(row_q);
    end
    if (cmd_i.adv_rd) rd_en = 1'b1;
    if (cmd_i.adv_load) begin
      rd_en   = 1'b1;
      rd_addr = AW'(1);
    end
    if (cmd_i.adv_row) begin
      rd_en   = (32'(r_q) + 2) < ROWS;
      rd_addr = r_q + AW'(2);
      wr_en   = 1'b1;
      wr_addr = r_q;
      wr_data = new_row;
    end
    if (cmd_i.clr_wr) begin
      wr_en   = 1'b1;
      wr_addr = clr_q;
    end
    if (cmd_i.cell_fin && in_grid && (act_q == lag_pkg::ACT_TOGGLE)) begin
      wr_en   = 1'b1;
      wr_addr = AW'(row_q);
      wr_data = rd_q ^ (COLS'(1) << col_idx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      act_q <= action_i;
      row_q <= row_i;
      col_q <= column_i;
    end
    if (cmd_i.adv_load) begin
      prev_q <= '0;
      cur_q  <= rd_q;
    end
    if (cmd_i.adv_row) begin
      prev_q <= cur_q;
      cur_q  <= below;
    end
    if (cmd_i.cell_fin) begin
      alive_q <= in_grid && ((act_q == lag_pkg::ACT_TOGGLE) ? !cell_bit :
                             (act_q == lag_pkg::ACT_QUERY) && cell_bit);
      done_q  <= (act_q != lag_pkg::ACT_NONE);
    end
    if (cmd_i.adv_row && sts_o.row_last) begin
      alive_q <= 1'b0;
      done_q  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      r_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) clr_q <= clr_q + AW'(1);
      if (cmd_i.adv_load) r_q <= '0;
      else if (cmd_i.adv_row) r_q <= r_q + AW'(1);
      if (cmd_i.cell_fin || (cmd_i.adv_row && sts_o.row_last)) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign alive_o     = alive_q;
  assign done_res_o  = done_q;

endmodule

### tb/life_automaton_grid_tb.sv
`timescale 1ns / 1ps
module life_automaton_grid_tb;

  localparam int ROWS = 64;
  localparam int COLS = 64;
  localparam longint LIMIT = 2000000;

  typedef struct packed {
    logic alive;
    logic done_res;
  } cell_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lag_in_if  in_ch ();
  lag_out_if out_ch ();

  life_automaton_grid #(.ROWS(ROWS), .COLS(COLS)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  logic [COLS-1:0] life_grid [ROWS];
  cell_result_t    pending_results [$];
  int              error_count = 0;
  longint          cycle_count = 0;
  int              burst_left = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.action = lag_pkg::ACT_NONE;
    in_ch.row    = '0;
    in_ch.column = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("life_automaton_grid regression: fail");
      $finish;
    end
  end

  // receiver stall pattern: long open stretches mixed with random stalls
  always @(posedge clk_i) begin
    int phase;
    phase = int'((cycle_count / 200) % 3);
    if (phase == 0)
      out_ch.ready <= 1'b1;
    else if (phase == 1)
      out_ch.ready <= ($urandom_range(0, 3) != 0);
    else
      out_ch.ready <= ($urandom_range(0, 1) != 0);
  end

  always @(posedge clk_i) begin
    cell_result_t got, want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.alive    = out_ch.alive;
      got.done_res = out_ch.done_res;
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t unexpected item: alive %0b done_res %0b", $time, got.alive,
                 got.done_res);
      end else begin
        want = pending_results.pop_front();
        if (got.alive !== want.alive) begin
          error_count++;
          $display("%0t alive mismatch: expected %0b actual %0b", $time, want.alive,
                   got.alive);
        end
        if (got.done_res !== want.done_res) begin
          error_count++;
          $display("%0t done_res mismatch: expected %0b actual %0b", $time,
                   want.done_res, got.done_res);
        end
      end
    end
  end

  function automatic logic cell_at(int r, int c);
    if (r < 0 || r >= ROWS || c < 0 || c >= COLS)
      return 1'b0;
    return life_grid[r][c];
  endfunction

  function automatic void step_generation();
    logic [COLS-1:0] next_gen [ROWS];
    int n;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++)
          for (int dc = -1; dc <= 1; dc++)
            if (dr != 0 || dc != 0)
              n += cell_at(r + dr, c + dc);
        if (life_grid[r][c])
          next_gen[r][c] = (n == lag_pkg::SURVIVE_LO || n == lag_pkg::BIRTH);
        else
          next_gen[r][c] = (n == lag_pkg::BIRTH);
      end
    end
    life_grid = next_gen;
  endfunction

  function automatic cell_result_t predict_action(lag_pkg::action_e act, int r, int c);
    cell_result_t res;
    logic in_grid;
    in_grid = (r < ROWS) && (c < COLS);
    res = '0;
    case (act)
      lag_pkg::ACT_TOGGLE: begin
        if (in_grid) begin
          life_grid[r][c] = ~life_grid[r][c];
          res.alive = life_grid[r][c];
        end
        res.done_res = 1'b1;
      end
      lag_pkg::ACT_ADVANCE: begin
        step_generation();
        res.done_res = 1'b1;
      end
      lag_pkg::ACT_QUERY: begin
        if (in_grid)
          res.alive = life_grid[r][c];
        res.done_res = 1'b1;
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  task automatic send_item(lag_pkg::action_e act, int r, int c);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.row    <= r[lag_pkg::COORD_W-1:0];
    in_ch.column <= c[lag_pkg::COORD_W-1:0];
    do @(posedge clk_i); while (!in_ch.ready);
    pending_results.push_back(predict_action(act, r, c));
  endtask

  task automatic test_corners();
    send_item(lag_pkg::ACT_QUERY, 0, 0);
    send_item(lag_pkg::ACT_TOGGLE, 0, 0);
    send_item(lag_pkg::ACT_TOGGLE, 63, 63);
    send_item(lag_pkg::ACT_TOGGLE, 0, 63);
    send_item(lag_pkg::ACT_TOGGLE, 63, 0);
    send_item(lag_pkg::ACT_QUERY, 63, 63);
    send_item(lag_pkg::ACT_TOGGLE, 63, 63);
    send_item(lag_pkg::ACT_QUERY, 63, 63);
    send_item(lag_pkg::ACT_NONE, 42, 21);
    send_item(lag_pkg::ACT_NONE, 63, 63);
  endtask

  // blinker on the top edge and a glider, then two generations
  task automatic test_patterns();
    send_item(lag_pkg::ACT_TOGGLE, 0, 30);
    send_item(lag_pkg::ACT_TOGGLE, 0, 31);
    send_item(lag_pkg::ACT_TOGGLE, 0, 32);
    send_item(lag_pkg::ACT_TOGGLE, 10, 11);
    send_item(lag_pkg::ACT_TOGGLE, 11, 12);
    send_item(lag_pkg::ACT_TOGGLE, 12, 10);
    send_item(lag_pkg::ACT_TOGGLE, 12, 11);
    send_item(lag_pkg::ACT_TOGGLE, 12, 12);
    send_item(lag_pkg::ACT_ADVANCE, 21, 42);
    send_item(lag_pkg::ACT_QUERY, 1, 31);
    send_item(lag_pkg::ACT_QUERY, 0, 31);
    send_item(lag_pkg::ACT_QUERY, 0, 30);
    send_item(lag_pkg::ACT_ADVANCE, 0, 0);
    send_item(lag_pkg::ACT_QUERY, 13, 11);
  endtask

  task automatic test_random();
    int r, c, a;
    for (int i = 0; i < 116; i++) begin
      a = $urandom_range(0, 99);
      r = $urandom_range(0, 63);
      c = $urandom_range(0, 63);
      if (a < 8) begin
        send_item(lag_pkg::ACT_ADVANCE, r, c);
      end else if (a < 55) begin
        // clustered toggles so advances see real neighborhoods
        if ($urandom_range(0, 3) != 0) begin
          r = $urandom_range(20, 27);
          c = $urandom_range(20, 27);
        end
        send_item(lag_pkg::ACT_TOGGLE, r, c);
      end else if (a < 95) begin
        send_item(lag_pkg::ACT_QUERY, r, c);
      end else begin
        send_item(lag_pkg::ACT_NONE, r, c);
      end
    end
  endtask

  initial begin
    for (int r = 0; r < ROWS; r++)
      life_grid[r] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_corners();
    test_patterns();
    test_random();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk_i);
    repeat (ROWS + 20) @(posedge clk_i);
    if (error_count == 0)
      $display("life_automaton_grid regression: pass");
    else
      $display("life_automaton_grid regression: fail");
    $finish;
  end

endmodule

### files.f
src/lag_pkg.sv
src/lag_in_if.sv
src/lag_out_if.sv
src/lag_ctrl.sv
src/lag_datapath.sv
src/life_automaton_grid.sv
tb/life_automaton_grid_tb.sv
